// ===== src/fppt_pkg.sv =====
// ---------------------------------------------------------------------------
// fppt_pkg: shared constants and types of the frame period phase tracker
// Field widths, acceptance windows and the phase correction shift.
// ---------------------------------------------------------------------------
package fppt_pkg;

	// field widths
	localparam int TS_W     = 32;
	localparam int PERIOD_W = 16;

	// acceptance windows around the target period, in microseconds
	localparam int SEED_WINDOW  = 100;
	localparam int TRACK_WINDOW = 60;

	// phase correction keeps err - err/16
	localparam int ERR_SHIFT = 4;

	typedef logic [PERIOD_W-1:0]        period_t;
	typedef logic signed [PERIOD_W-1:0] phase_t;
	typedef logic [TS_W-1:0]            stamp_t;

endpackage

// ===== src/fppt_in_if.sv =====
// ---------------------------------------------------------------------------
// fppt_in_if: trigger request channel
// Valid/ready channel carrying the eye flag and the arrival timestamp.
// ---------------------------------------------------------------------------
interface fppt_in_if;

	logic            valid;
	logic            ready;
	logic            is_left_eye;
	fppt_pkg::stamp_t arrival_time_us;

	modport source (output valid, output is_left_eye, output arrival_time_us, input ready);
	modport sink   (input valid, input is_left_eye, input arrival_time_us, output ready);

endinterface

// ===== src/fppt_out_if.sv =====
// ---------------------------------------------------------------------------
// fppt_out_if: tracking result channel
// Valid/ready channel carrying the eye flag, average period and phase adjust.
// ---------------------------------------------------------------------------
interface fppt_out_if;

	logic              valid;
	logic              ready;
	logic              eye_left;
	fppt_pkg::period_t average_frame_period;
	fppt_pkg::phase_t  phase_adjust;

	modport source (output valid, output eye_left, output average_frame_period,
		output phase_adjust, input ready);
	modport sink   (input valid, input eye_left, input average_frame_period,
		input phase_adjust, output ready);

endinterface

// ===== src/frame_period_phase_tracker_top.sv =====
// ---------------------------------------------------------------------------
// frame_period_phase_tracker_top: frame period and phase tracker
// Tracks the trigger period, keeps a running average and reports phase error.
// ---------------------------------------------------------------------------
// Accepts one trigger request per clock unless the output stalls; stage 1,
// stage 2, stage 3 and the output register carry it. The rate is set by the
// average update, which is combinational: a three-term add, a multiply by
// the constant reciprocal of HISTORY_DEPTH and a window compare. The last
// HISTORY_DEPTH stamps live in a chain of cells that shifts once per trigger
// after the first; a result appears only after the chain has been refilled
// since the last clear. Writing target_period clears all tracking state.
// Stalled results only block input once every pipeline stage holds a request.
module frame_period_phase_tracker_top #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fppt_pkg::PERIOD_W-1:0] cfg_data,
	fppt_in_if.sink                   trigger,
	fppt_out_if.source                result
);

	localparam int PW        = fppt_pkg::PERIOD_W;
	localparam int LOG_N     = $clog2(HISTORY_DEPTH);
	localparam int PTR_W     = (LOG_N > 0) ? LOG_N : 1;
	// scaled average stays below 2^16 * HISTORY_DEPTH
	localparam int AVG_W     = PW + LOG_N;
	localparam int DIV_SHIFT = AVG_W + LOG_N;
	localparam int RECIP_W   = PW + 1 + LOG_N;
	localparam int PROD_W    = AVG_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << DIV_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
	localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

	// configuration and tracking state
	fppt_pkg::period_t   target_q;
	fppt_pkg::period_t   last_q;
	logic                last_valid_q;
	logic                avg_valid_q;
	logic                full_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [AVG_W-1:0]    avg_q;
	fppt_pkg::period_t   avgq_q;

	// stage 1
	logic                v_s1;
	logic                eye_s1;
	logic                have_last_s1;
	fppt_pkg::period_t   now_s1;
	fppt_pkg::period_t   period_s1;
	logic                over_s1;
	logic                in_seed_s1;

	// stage 2
	logic                v_s2;
	logic                eye_s2;
	fppt_pkg::period_t   now_s2;
	fppt_pkg::period_t   avgq_s2;
	fppt_pkg::period_t   oldest_s2;
	fppt_pkg::period_t   avg16_s2;

	// stage 3
	logic                v_s3;
	logic                eye_s3;
	fppt_pkg::period_t   now_s3;
	fppt_pkg::period_t   avgq_s3;
	fppt_pkg::period_t   expected_s3;

	// output register
	logic                out_v_q;
	logic                out_eye_q;
	fppt_pkg::period_t   out_avg_q;
	fppt_pkg::phase_t    out_adj_q;

	// stage advance: a stage loads when empty or when its contents move on
	logic out_free, ld3, ld2, ld1, accept, step2;

	assign out_free = !out_v_q || result.ready;
	assign ld3      = !v_s3 || out_free;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign accept   = trigger.valid && ld1;
	assign step2    = v_s1 && ld2;

	assign trigger.ready = ld1;

	// stage 0: period and window flags
	fppt_pkg::period_t  now_in, period_in;
	logic signed [PW+1:0] t_ext, p_ext, seed_lo, seed_hi;
	logic               over_in, in_seed_in;

	always_comb begin
		now_in     = trigger.arrival_time_us[PW-1:0];
		period_in  = now_in - last_q;
		t_ext      = signed'({2'b00, target_q});
		p_ext      = signed'({2'b00, period_in});
		seed_lo    = t_ext - signed'((PW+2)'(fppt_pkg::SEED_WINDOW));
		seed_hi    = t_ext + signed'((PW+2)'(fppt_pkg::SEED_WINDOW));
		over_in    = {1'b0, period_in} > {target_q, 1'b0};
		in_seed_in = (p_ext >= seed_lo) && (p_ext <= seed_hi);
	end

	// stage 2: average update
	logic                 tzero, clr;
	logic                 av0, full0;
	logic [AVG_W-1:0]     avg0, cand, seed_avg, avg_n;
	fppt_pkg::period_t    q0, cq, q_n;
	logic [PTR_W-1:0]     ptr0, ptr_n;
	logic                 av_n, full_n, res2;
	logic [PROD_W-1:0]    prod;
	logic signed [PW+1:0] c_ext, trk_lo, trk_hi;
	logic                 track_ok;
	fppt_pkg::period_t    oldest;

	always_comb begin
		tzero    = (target_q == '0);
		clr      = have_last_s1 && over_s1;
		av0      = clr ? 1'b0 : avg_valid_q;
		full0    = clr ? 1'b0 : full_q;
		avg0     = clr ? '0 : avg_q;
		q0       = clr ? '0 : avgq_q;
		ptr0     = clr ? '0 : ptr_q;

		// candidate average and its quotient by HISTORY_DEPTH
		cand     = avg0 - AVG_W'(q0) + AVG_W'(period_s1);
		prod     = PROD_W'(cand) * PROD_W'(RECIP);
		cq       = prod[DIV_SHIFT +: PW];
		c_ext    = signed'({2'b00, cq});
		trk_lo   = t_ext - signed'((PW+2)'(fppt_pkg::TRACK_WINDOW));
		trk_hi   = t_ext + signed'((PW+2)'(fppt_pkg::TRACK_WINDOW));
		track_ok = tzero || ((c_ext >= trk_lo) && (c_ext <= trk_hi));
		seed_avg = AVG_W'(period_s1) * AVG_W'(HISTORY_DEPTH);

		if (av0) begin
			av_n  = 1'b1;
			avg_n = track_ok ? cand : avg0;
			q_n   = track_ok ? cq : q0;
		end else if (tzero || in_seed_s1) begin
			av_n  = 1'b1;
			avg_n = seed_avg;
			q_n   = period_s1;
		end else begin
			av_n  = 1'b0;
			avg_n = avg0;
			q_n   = q0;
		end

		// history fill count
		ptr_n  = (ptr0 == PTR_LAST) ? '0 : ptr0 + PTR_W'(1);
		full_n = full0 || (ptr0 == PTR_LAST);
		res2   = have_last_s1 && av0 && full0;
	end

	// history chain of cells
	fppt_history #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (PW)
	) u_history (
		.clk        (clk),
		.shift_en   (step2 && have_last_s1),
		.shift_data (now_s1),
		.tail       (oldest)
	);

	// output stage: phase error and its correction
	fppt_pkg::phase_t err, adj;

	always_comb begin
		err = signed'(now_s3 - expected_s3);
		adj = err - (err >>> fppt_pkg::ERR_SHIFT);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			last_valid_q <= 1'b0;
			avg_valid_q  <= 1'b0;
			full_q       <= 1'b0;
			ptr_q        <= '0;
			avg_q        <= '0;
			avgq_q       <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				target_q     <= cfg_data;
				last_valid_q <= 1'b0;
				avg_valid_q  <= 1'b0;
				full_q       <= 1'b0;
				ptr_q        <= '0;
				avg_q        <= '0;
				avgq_q       <= '0;
			end else begin
				if (accept) begin
					last_valid_q <= 1'b1;
				end
				if (step2 && have_last_s1) begin
					avg_valid_q <= av_n;
					full_q      <= full_n;
					ptr_q       <= ptr_n;
					avg_q       <= avg_n;
					avgq_q      <= q_n;
				end
			end
			if (ld1) begin
				v_s1 <= accept;
			end
			if (ld2) begin
				v_s2 <= step2 && res2;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				out_v_q <= v_s3;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q       <= now_in;
			eye_s1       <= trigger.is_left_eye;
			have_last_s1 <= last_valid_q;
			now_s1       <= now_in;
			period_s1    <= period_in;
			over_s1      <= over_in;
			in_seed_s1   <= in_seed_in;
		end
		if (ld2) begin
			eye_s2    <= eye_s1;
			now_s2    <= now_s1;
			avgq_s2   <= q_n;
			oldest_s2 <= oldest;
			avg16_s2  <= avg_n[PW-1:0];
		end
		if (ld3) begin
			eye_s3      <= eye_s2;
			now_s3      <= now_s2;
			avgq_s3     <= avgq_s2;
			expected_s3 <= oldest_s2 + avg16_s2;
		end
		if (out_free) begin
			out_eye_q <= eye_s3;
			out_avg_q <= avgq_s3;
			out_adj_q <= adj;
		end
	end

	assign result.valid                = out_v_q;
	assign result.eye_left             = out_eye_q;
	assign result.average_frame_period = out_avg_q;
	assign result.phase_adjust         = out_adj_q;

endmodule

// ===== src/fppt_cell.sv =====
// ---------------------------------------------------------------------------
// fppt_cell: one timestamp cell of the history chain
// Holds one stored timestamp and passes it on to the next cell on a shift.
// ---------------------------------------------------------------------------
module fppt_cell #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             shift_en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] data_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

// ===== src/fppt_history.sv =====
// ---------------------------------------------------------------------------
// fppt_history: chain of timestamp cells
// Each shift moves every stored stamp one cell on; the last cell holds the
// stamp written DEPTH shifts ago.
// ---------------------------------------------------------------------------
module fppt_history #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             shift_en,
	input  logic [WIDTH-1:0] shift_data,
	output logic [WIDTH-1:0] tail
);

	logic [WIDTH-1:0] tap [DEPTH];

	// cell 0 takes the new stamp, every other cell its left neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			fppt_cell #(.WIDTH(WIDTH)) u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d        (shift_data),
				.q        (tap[i])
			);
		end else begin : g_body
			fppt_cell #(.WIDTH(WIDTH)) u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.d        (tap[i-1]),
				.q        (tap[i])
			);
		end
	end

	assign tail = tap[DEPTH-1];

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: frame period phase tracker
// Drives trigger requests through several target period settings and checks
// every tracking result against a cycle-free predictor of the tracker.
// ---------------------------------------------------------------------------
module testbench;

	localparam int DEPTH       = 64;
	localparam int DRAIN       = 12;    // cycles past the last result before a write
	localparam int STALL_LIMIT = 2000;  // cycles without any handshake
	localparam int PHASE_ITEMS = 240;

	typedef struct {
		logic              eye;
		fppt_pkg::period_t avg;
		fppt_pkg::phase_t  phase;
	} tracker_result_t;

	// -----------------------------------------------------------------------
	// predictor of the tracker and store of the results it owes
	// -----------------------------------------------------------------------
	class fppt_scoreboard;
		fppt_pkg::period_t target;
		fppt_pkg::stamp_t  prev_stamp;
		bit                prev_seen;
		bit                avg_live;
		bit                ring_full;
		fppt_pkg::stamp_t  stamp_ring [DEPTH];
		int unsigned       ring_ptr;
		logic [31:0]       avg_x64;
		tracker_result_t   owed_results [$];
		int                n_errors;
		int                n_checked;
		int                n_triggers;

		function new();
			target     = '0;
			n_errors   = 0;
			n_checked  = 0;
			n_triggers = 0;
			clear_tracking();
		endfunction

		function void clear_tracking();
			prev_stamp = '0;
			prev_seen  = 1'b0;
			avg_live   = 1'b0;
			ring_full  = 1'b0;
			ring_ptr   = 0;
			avg_x64    = '0;
			foreach (stamp_ring[k])
				stamp_ring[k] = '0;
		endfunction

		function void set_target(fppt_pkg::period_t value);
			target = value;
			clear_tracking();
		endfunction

		function bit in_window(int value, int span);
			return value >= int'(target) - span && value <= int'(target) + span;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		task report_mismatch(string msg);
			n_errors++;
			$display("MISMATCH at %0t: %0s", $realtime, msg);
		endtask

		// one accepted trigger request advances the tracker state
		function void note_trigger(logic eye, fppt_pkg::stamp_t now);
			fppt_pkg::period_t period;
			logic [31:0]       cand;
			logic [15:0]       cand16;
			fppt_pkg::stamp_t  predicted;
			logic [15:0]       diff;
			int                err;
			tracker_result_t   res;
			n_triggers++;
			if (prev_seen) begin
				period = fppt_pkg::PERIOD_W'(now - prev_stamp);
				// overlong period drops the average and the ring
				if (32'(period) > (32'(target) << 1)) begin
					avg_live  = 1'b0;
					ring_full = 1'b0;
					ring_ptr  = 0;
					avg_x64   = '0;
				end
				if (avg_live) begin
					cand   = avg_x64 - avg_x64 / DEPTH + 32'(period);
					cand16 = 16'(cand / DEPTH);
					if (target == 0 || in_window(int'(cand16), fppt_pkg::TRACK_WINDOW))
						avg_x64 = cand;
					if (ring_full) begin
						predicted = stamp_ring[ring_ptr] + avg_x64;
						diff      = 16'(now - predicted);
						err       = int'($signed(diff));
						res.eye   = eye;
						res.avg   = fppt_pkg::PERIOD_W'(avg_x64 / DEPTH);
						res.phase = fppt_pkg::phase_t'(err - (err >>> fppt_pkg::ERR_SHIFT));
						owed_results.push_back(res);
					end
				end else if (target == 0 || in_window(int'(period), fppt_pkg::SEED_WINDOW)) begin
					avg_x64  = 32'(period) * DEPTH;
					avg_live = 1'b1;
				end
				// every trigger after the first lands in the ring
				stamp_ring[ring_ptr] = now;
				ring_ptr = (ring_ptr + 1) % DEPTH;
				if (ring_ptr == 0)
					ring_full = 1'b1;
			end
			prev_stamp = now;
			prev_seen  = 1'b1;
		endfunction

		task check_result(logic eye, fppt_pkg::period_t avg, fppt_pkg::phase_t phase);
			tracker_result_t want;
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("result with none owed: eye %0b avg %0d phase %0d",
					eye, avg, phase));
				return;
			end
			want = owed_results.pop_front();
			n_checked++;
			if (eye !== want.eye)
				report_mismatch($sformatf("eye_left %0b, want %0b", eye, want.eye));
			if (avg !== want.avg)
				report_mismatch($sformatf("average_frame_period %0d, want %0d", avg, want.avg));
			if (phase !== want.phase)
				report_mismatch($sformatf("phase_adjust %0d, want %0d", phase, want.phase));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	fppt_pkg::period_t cfg_data;

	fppt_in_if  trigger ();
	fppt_out_if result ();

	fppt_scoreboard sb = new();

	bit               tx_burst;
	bit               rx_burst;
	fppt_pkg::stamp_t sent_stamp;
	int               n_settings;
	int               idle_cycles = 0;

	frame_period_phase_tracker_top #(
		.HISTORY_DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.trigger (trigger.sink),
		.result  (result.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitors: sample handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n && trigger.valid && trigger.ready)
			sb.note_trigger(trigger.is_left_eye, trigger.arrival_time_us);
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result(result.eye_left, result.average_frame_period, result.phase_adjust);
	end

	// watchdog on handshake inactivity
	always @(posedge clk) begin
		if ((trigger.valid && trigger.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result receiver with random back-pressure
	initial begin
		int d;
		result.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			d = rx_burst ? 0 : $urandom_range(0, 3);
			if (d > 0) begin
				result.ready <= 1'b0;
				repeat (d) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			@(negedge clk);
		end
	end

	// one trigger request; entered and left at a falling edge
	task automatic send_trigger(logic eye, fppt_pkg::stamp_t ts);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			trigger.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		trigger.valid           <= 1'b1;
		trigger.is_left_eye     <= eye;
		trigger.arrival_time_us <= ts;
		do @(posedge clk); while (!trigger.ready);
		@(negedge clk);
		sent_stamp = ts;
	endtask

	// stop requesting and let every owed result come out
	task automatic drain_results();
		trigger.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_target(fppt_pkg::period_t value);
		drain_results();
		repeat (DRAIN) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_target(value);
		n_settings++;
	endtask

	// edges of the stamp range, wrap, clear and window boundaries
	task automatic run_directed();
		fppt_pkg::stamp_t base;
		send_trigger(1'b1, 32'h0000_0000);  // first request only records
		send_trigger(1'b0, 32'h0000_0000);  // zero period seeds with target off
		send_trigger(1'b1, 32'hFFFF_FFFF);  // overlong period clears, reseeds
		send_trigger(1'b0, 32'hFFFF_FFFF);
		send_trigger(1'b1, 32'h0000_FFFF);  // period truncates to zero
		send_trigger(1'b0, 32'h8000_0000);
		send_trigger(1'b1, 32'h7FFF_FFFF);
		send_trigger(1'b0, 32'hAAAA_AAAA);
		send_trigger(1'b1, 32'h5555_5555);
		send_trigger(1'b0, 32'h5555_5555);
		write_target(16'd1000);
		base = 32'h1234_F000;
		send_trigger(1'b1, base);
		send_trigger(1'b0, base + 32'd2000);   // exactly twice target: kept, no seed
		send_trigger(1'b1, base + 32'd4001);   // just over twice target: cleared
		send_trigger(1'b0, base + 32'd5101);   // seed at the top of the window
		send_trigger(1'b1, base + 32'd6162);   // candidate average outside tracking window
		send_trigger(1'b0, base + 32'd7162);
		send_trigger(1'b1, base + 32'd8062);
		send_trigger(1'b0, base + 32'd8962);   // period at seed window low edge; average still live
		send_trigger(1'b1, base + 32'd9863);
	endtask

	// one target setting: mostly well-formed periods with jitter, some noise
	task automatic run_phase(fppt_pkg::period_t target, int n_items);
		int               r;
		int               span;
		int               p;
		fppt_pkg::stamp_t ts;
		write_target(target);
		for (int k = 0; k < n_items; k++) begin
			if (k % 50 == 0) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			if (k == n_items / 2)
				drain_results();
			r = $urandom_range(0, 299);
			if (r == 0) begin
				ts = $urandom;
			end else if (r == 1) begin
				ts = sent_stamp + 32'(2 * int'(target) + 1 + $urandom_range(0, 99));
			end else begin
				if (r < 30)
					span = (target < 240) ? int'(target) : 120;
				else
					span = (target < 80) ? int'(target) : 40;
				p  = int'(target) + int'($urandom_range(0, 2 * span)) - span;
				ts = sent_stamp + 32'(p);
				if (r < 6)
					ts = ts + 32'h1_0000 * $urandom_range(1, 3);
			end
			send_trigger(1'($urandom_range(0, 1)), ts);
		end
	endtask

	// main sequence
	initial begin
		fppt_pkg::period_t targets [7];
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_data                = '0;
		trigger.valid           = 1'b0;
		trigger.is_left_eye     = 1'b0;
		trigger.arrival_time_us = '0;
		tx_burst                = 1'b0;
		rx_burst                = 1'b0;
		n_settings = 0;
		sent_stamp = $urandom;
		targets[0] = 16'd0;
		targets[1] = 16'd1;
		targets[2] = 16'hFFFF;
		targets[3] = 16'd16667;
		targets[4] = 16'd8333;
		targets[5] = 16'($urandom_range(200, 40000));
		targets[6] = 16'd100;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		foreach (targets[i])
			run_phase(targets[i], PHASE_ITEMS);

		drain_results();
		repeat (DRAIN) @(negedge clk);

		$display("Sent %0d trigger requests over %0d target settings; %0d results checked.",
			sb.n_triggers, n_settings, sb.n_checked);
		if (sb.n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", sb.n_errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
